// File: src/tsit_pkg.sv
// ---------------------------------------------------------------------------
// tsit_pkg
// Shared types and constants for the table search / interpolation block.
// ---------------------------------------------------------------------------
package tsit_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int VALUE_WIDTH = 24;
    localparam int ADDR_WIDTH  = $clog2(TABLE_DEPTH);
    localparam int CNT_WIDTH   = $clog2(TABLE_DEPTH + 1);
    localparam int FRAC_BITS   = 8;
    localparam int TEMP_WIDTH  = 17;
    localparam int OFFS_WIDTH  = 8;

    typedef logic [VALUE_WIDTH-1:0] value_t;
    typedef logic [ADDR_WIDTH-1:0]  addr_t;
    typedef logic [CNT_WIDTH-1:0]   cnt_t;
    typedef logic [FRAC_BITS-1:0]   quot_t;

    // configuration register indexes
    localparam logic [1:0] CFG_MIN_VALID = 2'd0;
    localparam logic [1:0] CFG_MAX_VALID = 2'd1;
    localparam logic [1:0] CFG_ENTRIES   = 2'd2;
    localparam logic [1:0] CFG_OFFSET    = 2'd3;

    // request kinds
    localparam logic REQ_LOAD    = 1'b0;
    localparam logic REQ_CONVERT = 1'b1;

    localparam value_t                MIN_VALID_RST = '0;
    localparam value_t                MAX_VALID_RST = '1;
    localparam cnt_t                  ENTRIES_RST   = CNT_WIDTH'(TABLE_DEPTH);
    localparam logic [OFFS_WIDTH-1:0] OFFSET_RST    = OFFS_WIDTH'(59);

endpackage

// File: src/tsit_div.sv
// ---------------------------------------------------------------------------
// tsit_div
// Restoring serial divider: quot = floor(numer * 2^FRAC_BITS / denom),
// one quotient bit per cycle. Requires numer < denom.
// ---------------------------------------------------------------------------
module tsit_div
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  tsit_pkg::value_t numer,
    input  tsit_pkg::value_t denom,
    output logic             done,
    output tsit_pkg::quot_t  quot
);

    localparam int STEP_W = $clog2(tsit_pkg::FRAC_BITS + 1);

    tsit_pkg::value_t                  rem_reg;
    tsit_pkg::value_t                  denom_reg;
    tsit_pkg::quot_t                   quot_reg;
    logic [STEP_W-1:0]                 step_reg;
    logic                              busy_reg;
    logic                              done_reg;
    logic [tsit_pkg::VALUE_WIDTH:0]    rem_shift;
    logic                              fits;

    assign rem_shift = {rem_reg, 1'b0};
    assign fits      = rem_shift >= {1'b0, denom_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(tsit_pkg::FRAC_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg   <= numer;
            denom_reg <= denom;
            quot_reg  <= '0;
        end
        else if (busy_reg)
        begin
            // remainder stays below denom, so the low bits hold it exactly
            if (fits)
                rem_reg <= tsit_pkg::VALUE_WIDTH'(rem_shift - {1'b0, denom_reg});
            else
                rem_reg <= rem_shift[tsit_pkg::VALUE_WIDTH-1:0];
            quot_reg <= {quot_reg[tsit_pkg::FRAC_BITS-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

`ifndef ASSERT_OFF
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider restarted while busy");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running divide");
`endif

endmodule

// File: src/table_search_interpolate_temperature.sv
// A load word is taken while idle. An out-of-range convert goes straight to the
// output register; an in-range convert runs a binary search (two states per
// probe over the single table read port, at most nine probes), fetches the segment
// ends, runs the bit-serial fraction divide (eight quotient bits) and loads the
// output register once the result side is free. No new word is taken until then.
// Reset restores configuration defaults; table contents stay undefined until loaded.
// ---------------------------------------------------------------------------
// table_search_interpolate_temperature
// Calibration table lookup: binary search plus linear interpolation to Q.8.
// ---------------------------------------------------------------------------
module table_search_interpolate_temperature
(
    input  logic        clk,
    input  logic        rst_n,
    // config write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // entry_index[7:0], entry_value[31:8], reading[55:32]
    input  logic        s_tuser,   // req_type
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // temp_q8[16:0], zero pad [23:17]
    output logic        m_tuser    // out_of_range
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_PROBE   = 3'd1;
    localparam logic [2:0] ST_COMPARE = 3'd2;
    localparam logic [2:0] ST_SEG_A   = 3'd3;
    localparam logic [2:0] ST_SEG_B   = 3'd4;
    localparam logic [2:0] ST_SEG_C   = 3'd5;
    localparam logic [2:0] ST_DIV     = 3'd6;
    localparam logic [2:0] ST_DONE    = 3'd7;

    localparam int AW = tsit_pkg::ADDR_WIDTH;
    localparam int CW = tsit_pkg::CNT_WIDTH;
    localparam int FW = tsit_pkg::FRAC_BITS + 1;
    localparam int TW = tsit_pkg::TEMP_WIDTH;
    localparam int BW = AW + 2;

    // configuration
    tsit_pkg::value_t                  min_valid_reg;
    tsit_pkg::value_t                  max_valid_reg;
    tsit_pkg::cnt_t                    entries_reg;
    logic [tsit_pkg::OFFS_WIDTH-1:0]   offset_reg;

    // sequencer
    logic [2:0]       state_reg, state_next;
    tsit_pkg::value_t reading_reg, reading_next;
    tsit_pkg::cnt_t   start_reg, start_next;
    tsit_pkg::addr_t  end_reg, end_next;
    tsit_pkg::addr_t  mid_reg, mid_next;
    tsit_pkg::addr_t  lo_reg, lo_next;
    tsit_pkg::value_t a_reg, a_next;
    logic [FW-1:0]    frac_reg, frac_next;
    logic             oor_reg, oor_next;

    // output register
    logic             m_valid_reg, m_valid_next;
    logic [TW-1:0]    m_temp_reg, m_temp_next;
    logic             m_oor_reg, m_oor_next;

    // table memory
    tsit_pkg::value_t table_mem [tsit_pkg::TABLE_DEPTH];
    tsit_pkg::value_t rd_data_reg;
    tsit_pkg::addr_t  rd_addr;
    logic             mem_we;

    // divider
    logic             div_start;
    tsit_pkg::value_t div_numer;
    tsit_pkg::value_t div_denom;
    logic             div_done;
    tsit_pkg::quot_t  div_quot;

    logic             in_fire;
    tsit_pkg::addr_t  in_index;
    tsit_pkg::value_t in_value;
    tsit_pkg::value_t in_reading;
    tsit_pkg::cnt_t   n_eff;
    tsit_pkg::addr_t  last_idx;
    tsit_pkg::addr_t  seg_max;
    tsit_pkg::addr_t  probe_mid;
    tsit_pkg::cnt_t   step_up;
    tsit_pkg::addr_t  lo_exit;
    logic             do_exit;
    logic             out_free;
    logic [BW-1:0]    base_deg;
    logic [TW:0]      temp_full;

    assign in_index   = s_tdata[7:0];
    assign in_value   = s_tdata[31:8];
    assign in_reading = s_tdata[55:32];

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign mem_we   = in_fire && (s_tuser == tsit_pkg::REQ_LOAD);
    assign out_free = !m_valid_reg || m_tready;

    // entry count clamped to [2, TABLE_DEPTH]
    always_comb
    begin
        if (entries_reg < CW'(2))
            n_eff = CW'(2);
        else if (entries_reg > CW'(tsit_pkg::TABLE_DEPTH))
            n_eff = CW'(tsit_pkg::TABLE_DEPTH);
        else
            n_eff = entries_reg;
    end
    assign last_idx = AW'(n_eff - CW'(1));
    assign seg_max  = AW'(n_eff - CW'(2));

    assign probe_mid = AW'((start_reg + {1'b0, end_reg}) >> 1);
    assign step_up   = {1'b0, mid_reg} + CW'(1);

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_valid_reg <= tsit_pkg::MIN_VALID_RST;
            max_valid_reg <= tsit_pkg::MAX_VALID_RST;
            entries_reg   <= tsit_pkg::ENTRIES_RST;
            offset_reg    <= tsit_pkg::OFFSET_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                tsit_pkg::CFG_MIN_VALID: min_valid_reg <= cfg_wdata;
                tsit_pkg::CFG_MAX_VALID: max_valid_reg <= cfg_wdata;
                tsit_pkg::CFG_ENTRIES:   entries_reg   <= cfg_wdata[CW-1:0];
                tsit_pkg::CFG_OFFSET:    offset_reg    <= cfg_wdata[tsit_pkg::OFFS_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            table_mem[in_index] <= in_value;
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= table_mem[rd_addr];
    end

    always_comb
    begin
        case (state_reg)
            ST_PROBE: rd_addr = probe_mid;
            ST_SEG_A: rd_addr = lo_reg;
            ST_SEG_B: rd_addr = lo_reg + AW'(1);
            default:  rd_addr = mid_reg;
        endcase
    end

    // temperature = (lo - offset) * 256 + fraction
    assign base_deg  = BW'({2'b00, lo_reg}) - BW'({2'b00, offset_reg});
    assign temp_full = {base_deg, {tsit_pkg::FRAC_BITS{1'b0}}}
                       + (TW + 1)'({{(TW + 1 - FW){1'b0}}, frac_reg});

    assign div_numer = reading_reg - a_reg;
    assign div_denom = rd_data_reg - a_reg;

    always_comb
    begin
        state_next   = state_reg;
        reading_next = reading_reg;
        start_next   = start_reg;
        end_next     = end_reg;
        mid_next     = mid_reg;
        lo_next      = lo_reg;
        a_next       = a_reg;
        frac_next    = frac_reg;
        oor_next     = oor_reg;
        m_valid_next = m_valid_reg;
        m_temp_next  = m_temp_reg;
        m_oor_next   = m_oor_reg;
        div_start    = 1'b0;
        do_exit      = 1'b0;
        lo_exit      = mid_reg;

        if (m_valid_reg && m_tready)
            m_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (s_tuser == tsit_pkg::REQ_CONVERT))
                begin
                    reading_next = in_reading;
                    start_next   = '0;
                    end_next     = last_idx;
                    frac_next    = '0;
                    if ((in_reading > max_valid_reg) || (in_reading < min_valid_reg))
                    begin
                        oor_next   = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        oor_next   = 1'b0;
                        state_next = ST_PROBE;
                    end
                end
            end
            ST_PROBE:
            begin
                mid_next   = probe_mid;
                state_next = ST_COMPARE;
            end
            ST_COMPARE:
            begin
                if (reading_reg > rd_data_reg)
                begin
                    start_next = step_up;
                    lo_exit    = mid_reg;
                    do_exit    = step_up > {1'b0, end_reg};
                end
                else if (reading_reg < rd_data_reg)
                begin
                    if (mid_reg == '0)
                    begin
                        lo_exit = '0;
                        do_exit = 1'b1;
                    end
                    else
                    begin
                        end_next = mid_reg - AW'(1);
                        lo_exit  = mid_reg - AW'(1);
                        do_exit  = start_reg > {1'b0, end_next};
                    end
                end
                else
                begin
                    // exact hit: no fraction
                    lo_next    = mid_reg;
                    frac_next  = '0;
                    state_next = ST_DONE;
                end

                if (reading_reg != rd_data_reg)
                begin
                    if (do_exit)
                    begin
                        lo_next    = (lo_exit > seg_max) ? seg_max : lo_exit;
                        state_next = ST_SEG_A;
                    end
                    else
                    begin
                        state_next = ST_PROBE;
                    end
                end
            end
            ST_SEG_A:
            begin
                state_next = ST_SEG_B;
            end
            ST_SEG_B:
            begin
                a_next     = rd_data_reg;
                state_next = ST_SEG_C;
            end
            ST_SEG_C:
            begin
                // rd_data_reg holds the upper end of the segment
                if ((rd_data_reg <= a_reg) || (reading_reg < a_reg))
                begin
                    frac_next  = '0;
                    state_next = ST_DONE;
                end
                else if (reading_reg >= rd_data_reg)
                begin
                    frac_next  = FW'(1 << tsit_pkg::FRAC_BITS);
                    state_next = ST_DONE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    frac_next  = {1'b0, div_quot};
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_oor_next   = oor_reg;
                    m_temp_next  = oor_reg ? '0 : temp_full[TW-1:0];
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        reading_reg <= reading_next;
        start_reg   <= start_next;
        end_reg     <= end_next;
        mid_reg     <= mid_next;
        lo_reg      <= lo_next;
        a_reg       <= a_next;
        frac_reg    <= frac_next;
        oor_reg     <= oor_next;
        m_temp_reg  <= m_temp_next;
        m_oor_reg   <= m_oor_next;
    end

    tsit_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (div_numer),
        .denom (div_denom),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(24 - TW){1'b0}}, m_temp_reg};
    assign m_tuser  = m_oor_reg;

`ifndef ASSERT_OFF
    a_probe_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMPARE) |-> (mid_reg <= last_idx))
        else $error("search probe beyond last entry in use");
    a_segment_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEG_A) |-> (lo_reg <= seg_max))
        else $error("segment index beyond next-to-last entry");
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("out-of-range result with nonzero temperature");
    a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide step");
`endif

endmodule

// File: test/table_search_interpolate_temperature_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// table_search_interpolate_temperature_tb
// Loads ascending calibration tables, converts readings across and just outside
// the valid window, and checks every result word against an in-bench lookup model
// or a fixed expected value while both stream sides idle and stall at random.
// ---------------------------------------------------------------------------
module table_search_interpolate_temperature_tb;

    localparam int QUIET_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 250;
    localparam int SETTLE_CYCLES = 40;
    localparam int RAND_ITEMS    = 870;
    localparam int PHASE_ITEMS   = 45;
    localparam int NUM_ROWS      = 30;

    typedef struct packed {
        logic signed [tsit_pkg::TEMP_WIDTH-1:0] temp;
        logic                                   oor;
    } temp_res_t;

    typedef enum logic [1:0] {ROW_LOAD, ROW_CONV, ROW_CFG} row_kind_t;

    // val holds the entry value, the reading or the register value
    typedef struct packed {
        row_kind_t                              kind;
        logic [7:0]                             idx;
        logic [23:0]                            val;
        logic                                   fixed;
        logic signed [tsit_pkg::TEMP_WIDTH-1:0] exp_temp;
        logic                                   exp_oor;
    } dir_row_t;

    // Table is i * 0x10000 + 0x100 before these rows run.
    localparam dir_row_t DIR_ROWS [NUM_ROWS] = '{
        '{ROW_LOAD, 8'd0,   24'h000000, 1'b0, 17'sd0,      1'b0},
        '{ROW_LOAD, 8'd255, 24'hFFFFFF, 1'b0, 17'sd0,      1'b0},
        '{ROW_CONV, 8'd0,   24'h000000, 1'b1, -17'sd15104, 1'b0},
        '{ROW_CONV, 8'd0,   24'hFFFFFF, 1'b1, 17'sd50176,  1'b0},
        '{ROW_CONV, 8'd0,   24'h3B0100, 1'b1, 17'sd0,      1'b0},
        '{ROW_CONV, 8'd0,   24'h3B8100, 1'b1, 17'sd128,    1'b0},
        '{ROW_CONV, 8'd0,   24'h3B0101, 1'b0, 17'sd0,      1'b0},
        '{ROW_CONV, 8'd0,   24'h3B00FF, 1'b0, 17'sd0,      1'b0},
        '{ROW_CONV, 8'd0,   24'h000080, 1'b0, 17'sd0,      1'b0},
        '{ROW_CONV, 8'd0,   24'hFFFFFE, 1'b0, 17'sd0,      1'b0},
        // flat segment, then a descending one
        '{ROW_LOAD, 8'd100, 24'h630100, 1'b0, 17'sd0,      1'b0},
        '{ROW_CONV, 8'd0,   24'h630180, 1'b0, 17'sd0,      1'b0},
        '{ROW_CONV, 8'd0,   24'h630100, 1'b0, 17'sd0,      1'b0},
        '{ROW_LOAD, 8'd200, 24'h000000, 1'b0, 17'sd0,      1'b0},
        '{ROW_CONV, 8'd0,   24'hC70200, 1'b0, 17'sd0,      1'b0},
        '{ROW_CONV, 8'd0,   24'hC90000, 1'b0, 17'sd0,      1'b0},
        '{ROW_LOAD, 8'd100, 24'h640100, 1'b0, 17'sd0,      1'b0},
        '{ROW_LOAD, 8'd200, 24'hC80100, 1'b0, 17'sd0,      1'b0},
        // narrow window: flag just outside, convert on the edges
        '{ROW_CFG,  8'(tsit_pkg::CFG_MIN_VALID), 24'h100000, 1'b0, 17'sd0, 1'b0},
        '{ROW_CFG,  8'(tsit_pkg::CFG_MAX_VALID), 24'h200000, 1'b0, 17'sd0, 1'b0},
        '{ROW_CONV, 8'd0,   24'h0FFFFF, 1'b1, 17'sd0,      1'b1},
        '{ROW_CONV, 8'd0,   24'h200001, 1'b1, 17'sd0,      1'b1},
        '{ROW_CONV, 8'd0,   24'h100000, 1'b0, 17'sd0,      1'b0},
        '{ROW_CONV, 8'd0,   24'h200000, 1'b0, 17'sd0,      1'b0},
        // four entries, no offset: above the last entry clamps to segment 2
        '{ROW_CFG,  8'(tsit_pkg::CFG_MIN_VALID), 24'h000000, 1'b0, 17'sd0, 1'b0},
        '{ROW_CFG,  8'(tsit_pkg::CFG_MAX_VALID), 24'hFFFFFF, 1'b0, 17'sd0, 1'b0},
        '{ROW_CFG,  8'(tsit_pkg::CFG_ENTRIES),   24'd4,      1'b0, 17'sd0, 1'b0},
        '{ROW_CFG,  8'(tsit_pkg::CFG_OFFSET),    24'd0,      1'b0, 17'sd0, 1'b0},
        '{ROW_CONV, 8'd0,   24'h500000, 1'b1, 17'sd768,    1'b0},
        '{ROW_CONV, 8'd0,   24'h000000, 1'b1, 17'sd0,      1'b0}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [23:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;

    // lookup model state
    tsit_pkg::value_t cal_tbl [tsit_pkg::TABLE_DEPTH];
    tsit_pkg::value_t min_valid_q = tsit_pkg::MIN_VALID_RST;
    tsit_pkg::value_t max_valid_q = tsit_pkg::MAX_VALID_RST;
    logic [8:0]       entries_q   = 9'(tsit_pkg::ENTRIES_RST);
    logic [7:0]       offset_q    = tsit_pkg::OFFSET_RST;
    temp_res_t        pending_temps [$];

    int              mismatch_cnt = 0;
    int              quiet_cycles = 0;
    bit              idle_on = 1'b1;
    bit              hold_req = 1'b0;

    table_search_interpolate_temperature dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Binary search over the active entries, then linear interpolation.
    function automatic temp_res_t convert_reading(input tsit_pkg::value_t rdg);
        int unsigned      n;
        int unsigned      lo_i;
        int unsigned      hi_i;
        int unsigned      mid;
        int unsigned      seg;
        tsit_pkg::value_t dat;
        tsit_pkg::value_t a;
        tsit_pkg::value_t b;
        longint           t;
        longint           frac;
        temp_res_t        res;
        res = '0;
        if (rdg > max_valid_q || rdg < min_valid_q)
        begin
            res.oor = 1'b1;
            return res;
        end
        n = entries_q;
        if (n < 2) n = 2;
        if (n > tsit_pkg::TABLE_DEPTH) n = tsit_pkg::TABLE_DEPTH;
        lo_i = 0;
        hi_i = n - 1;
        mid = 0;
        dat = cal_tbl[0];
        while (lo_i <= hi_i)
        begin
            mid = (lo_i + hi_i) >> 1;
            dat = cal_tbl[mid];
            if (rdg > dat)
                lo_i = mid + 1;
            else if (rdg < dat)
            begin
                if (mid == 0) break;
                hi_i = mid - 1;
            end
            else
                break;
        end
        if (dat == rdg)
            t = (longint'(mid) - longint'(offset_q)) * 256;
        else
        begin
            if (dat > rdg)
                seg = (mid == 0) ? 0 : mid - 1;
            else
                seg = mid;
            if (seg > n - 2) seg = n - 2;
            a = cal_tbl[seg];
            b = cal_tbl[seg + 1];
            // saturate outside the segment, zero on a flat or falling one
            if (b <= a || rdg < a)
                frac = 0;
            else if (rdg >= b)
                frac = 256;
            else
                frac = (longint'(rdg) - longint'(a)) * 256 / (longint'(b) - longint'(a));
            t = (longint'(seg) - longint'(offset_q)) * 256 + frac;
        end
        if (t > 65535) t = 65535;
        if (t < -65536) t = -65536;
        res.temp = t[tsit_pkg::TEMP_WIDTH-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatch_cnt++;
    endtask

    // Offer one word, wait for it to be taken, then update the model.
    task automatic send_word(input logic req, input logic [7:0] idx,
                             input tsit_pkg::value_t val, input tsit_pkg::value_t rdg,
                             input bit fixed, input temp_res_t fixed_res);
        @(negedge clk);
        while (idle_on && $urandom_range(99) < 27)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {rdg, val, idx};
        do
            @(posedge clk);
        while (!s_tready);
        if (req == tsit_pkg::REQ_LOAD)
            cal_tbl[idx] = val;
        else
            pending_temps.push_back(fixed ? fixed_res : convert_reading(rdg));
    endtask

    // Drop valid, let every result out, then let loads finish.
    task automatic drain_block;
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_temps.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] ridx, input logic [23:0] rval);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= ridx;
        cfg_wdata <= rval;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (ridx)
            tsit_pkg::CFG_MIN_VALID: min_valid_q = rval;
            tsit_pkg::CFG_MAX_VALID: max_valid_q = rval;
            tsit_pkg::CFG_ENTRIES:   entries_q   = rval[8:0];
            tsit_pkg::CFG_OFFSET:    offset_q    = rval[7:0];
            default: ;
        endcase
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
                m_tready <= !(idle_on && $urandom_range(99) < 27);
        end
    end

    always @(posedge clk)
    begin
        temp_res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_temps.size() == 0)
                report_mismatch($sformatf("unexpected result word temp=%0d oor=%0b",
                                          $signed(m_tdata[tsit_pkg::TEMP_WIDTH-1:0]),
                                          m_tuser));
            else
            begin
                want = pending_temps.pop_front();
                if (m_tdata[tsit_pkg::TEMP_WIDTH-1:0] !== want.temp)
                    report_mismatch($sformatf("temp_q8 got %0d want %0d",
                                              $signed(m_tdata[tsit_pkg::TEMP_WIDTH-1:0]),
                                              want.temp));
                if (m_tuser !== want.oor)
                    report_mismatch($sformatf("out_of_range got %0b want %0b",
                                              m_tuser, want.oor));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        int               ph;
        int               k;
        int               pick;
        int               rand_items;
        int unsigned      n_eff;
        int unsigned      acc;
        int unsigned      max_step;
        int unsigned      lo_v;
        int unsigned      hi_v;
        int               edge_v;
        tsit_pkg::value_t rv;
        logic [23:0]      cmin;
        logic [23:0]      cmax;
        logic [8:0]       cent;
        logic [7:0]       coff;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // fill every entry so that no search ever meets an unwritten one
        for (k = 0; k < tsit_pkg::TABLE_DEPTH; k++)
            send_word(tsit_pkg::REQ_LOAD, 8'(k), 24'(k * 32'h10000 + 32'h100),
                      24'($urandom), 1'b0, '0);

        for (k = 0; k < NUM_ROWS; k++)
        begin
            case (DIR_ROWS[k].kind)
                ROW_LOAD: send_word(tsit_pkg::REQ_LOAD, DIR_ROWS[k].idx, DIR_ROWS[k].val,
                                    24'($urandom), 1'b0, '0);
                ROW_CONV: send_word(tsit_pkg::REQ_CONVERT, 8'($urandom), 24'($urandom),
                                    DIR_ROWS[k].val, DIR_ROWS[k].fixed,
                                    temp_res_t'{DIR_ROWS[k].exp_temp, DIR_ROWS[k].exp_oor});
                default:
                begin
                    drain_block();
                    write_reg(DIR_ROWS[k].idx[1:0], DIR_ROWS[k].val);
                end
            endcase
        end

        rand_items = 0;
        for (ph = 0; rand_items < RAND_ITEMS; ph++)
        begin
            case (ph)
                0: begin cmin = 24'h0;      cmax = 24'hFFFFFF; cent = 9'd256; coff = 8'd59;  end
                1: begin cmin = 24'h0;      cmax = 24'hFFFFFF; cent = 9'd2;   coff = 8'd0;   end
                2: begin cmin = 24'h0;      cmax = 24'hFFFFFF; cent = 9'd0;   coff = 8'd255; end
                3: begin cmin = 24'h0;      cmax = 24'hFFFFFF; cent = 9'd511; coff = 8'd128; end
                4:
                begin
                    cmin = 24'($urandom_range(0, 24'h7FFFFF));
                    cmax = 24'($urandom_range(cmin, 24'hFFFFFF));
                    cent = 9'd16;
                    coff = 8'd30;
                end
                5: begin cmin = 24'h800000; cmax = 24'h100000; cent = 9'd256; coff = 8'd59;  end
                6: begin cmin = 24'h0;      cmax = 24'hFFFFFF; cent = 9'd1;   coff = 8'd200; end
                7:
                begin
                    cmin = cal_tbl[$urandom_range(0, tsit_pkg::TABLE_DEPTH - 1)];
                    cmax = cmin;
                    cent = 9'd300;
                    coff = 8'd0;
                end
                default:
                begin
                    cmin = 24'($urandom_range(0, 24'h200000));
                    cmax = 24'($urandom_range(24'hD00000, 24'hFFFFFF));
                    cent = 9'($urandom_range(0, 511));
                    coff = 8'($urandom);
                end
            endcase
            drain_block();
            write_reg(tsit_pkg::CFG_MIN_VALID, cmin);
            write_reg(tsit_pkg::CFG_MAX_VALID, cmax);
            write_reg(tsit_pkg::CFG_ENTRIES, 24'(cent));
            write_reg(tsit_pkg::CFG_OFFSET, 24'(coff));
            n_eff = cent;
            if (n_eff < 2) n_eff = 2;
            if (n_eff > tsit_pkg::TABLE_DEPTH) n_eff = tsit_pkg::TABLE_DEPTH;
            idle_on = (ph != 3);
            if (ph == 1)
                hold_req = 1'b1;

            // fresh ascending table with random steps, some flat
            if (n_eff <= 32 || ph == 0 || ph == 3 || (ph >= 8 && $urandom_range(3) == 0))
            begin
                acc = $urandom_range(0, 4096);
                max_step = (32'hFFFFFF - acc) / n_eff;
                for (k = 0; k < int'(n_eff); k++)
                begin
                    send_word(tsit_pkg::REQ_LOAD, 8'(k), 24'(acc), 24'($urandom), 1'b0, '0);
                    rand_items++;
                    pick = $urandom_range(99);
                    if (pick < 8)
                        acc = acc;
                    else if (pick < 15)
                        acc = acc + $urandom_range(1, 3);
                    else
                        acc = acc + $urandom_range(1, max_step);
                end
            end

            repeat (PHASE_ITEMS)
            begin
                pick = $urandom_range(99);
                k = $urandom_range(0, n_eff - 1);
                if (pick < 10)
                    // noise: any entry, any value
                    send_word(tsit_pkg::REQ_LOAD, 8'($urandom), 24'($urandom), 24'($urandom),
                              1'b0, '0);
                else if (pick < 25)
                begin
                    // rewrite an entry between its neighbors
                    lo_v = (k == 0) ? 0 : cal_tbl[k - 1];
                    hi_v = (k == tsit_pkg::TABLE_DEPTH - 1) ? 32'hFFFFFF : cal_tbl[k + 1];
                    rv = (lo_v <= hi_v) ? 24'($urandom_range(lo_v, hi_v)) : 24'(lo_v);
                    send_word(tsit_pkg::REQ_LOAD, 8'(k), rv, 24'($urandom), 1'b0, '0);
                end
                else
                begin
                    pick = $urandom_range(99);
                    if (pick < 20)
                        rv = cal_tbl[k];
                    else if (pick < 55)
                    begin
                        if (k < int'(n_eff) - 1 && cal_tbl[k + 1] > cal_tbl[k])
                            rv = 24'($urandom_range(cal_tbl[k], cal_tbl[k + 1]));
                        else
                            rv = cal_tbl[k];
                    end
                    else if (pick < 65)
                    begin
                        edge_v = ($urandom_range(1) != 0) ? int'(min_valid_q) : int'(max_valid_q);
                        edge_v = edge_v + int'($urandom_range(0, 2)) - 1;
                        if (edge_v < 0) edge_v = 0;
                        if (edge_v > 32'hFFFFFF) edge_v = 32'hFFFFFF;
                        rv = 24'(edge_v);
                    end
                    else
                        rv = 24'($urandom);
                    send_word(tsit_pkg::REQ_CONVERT, 8'($urandom), 24'($urandom), rv, 1'b0, '0);
                end
                rand_items++;
            end
        end

        drain_block();
        if (mismatch_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: files.f
src/tsit_pkg.sv
src/tsit_div.sv
src/table_search_interpolate_temperature.sv
test/table_search_interpolate_temperature_tb.sv
